// ===== rtl/core/lcb_pkg.sv =====
// Shared types, constants and the ghost direction table for the linked-cell binning unit.
package lcb_pkg;

  localparam int POS_W     = 32;
  localparam int DOM_W     = 31;
  localparam int CELL_W    = 7;
  localparam int MAX_CELLS = 64;
  localparam int NUM_W     = POS_W + CELL_W;
  localparam int Q_W       = 7;
  localparam int REM_W     = DOM_W + Q_W;
  localparam int BIN_STG   = Q_W + 2;
  localparam int IDX_W     = 19;
  localparam int NGHOST    = 26;
  localparam int GSEL_W    = $clog2(NGHOST);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;
  localparam int MODES_W   = 12;
  localparam logic [1:0] MODE_PERIODIC = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DOMAIN_X = 3'd0,
    CFG_DOMAIN_Y = 3'd1,
    CFG_DOMAIN_Z = 3'd2,
    CFG_CELLS_X  = 3'd3,
    CFG_CELLS_Y  = 3'd4,
    CFG_CELLS_Z  = 3'd5,
    CFG_MODES    = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CLASS_INNER    = 2'd0,
    CLASS_BOUNDARY = 2'd1,
    CLASS_HALO     = 2'd2
  } cls_t;

  typedef enum logic [1:0] {
    ST_HOME  = 2'd0,
    ST_GHOST = 2'd1,
    ST_DROP  = 2'd2,
    ST_ERROR = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_PLUS  = 2'd1,
    DIR_MINUS = 2'd2
  } dir_t;

  // Effective per-axis setup derived from the registers.
  typedef struct packed {
    logic [CELL_W-1:0] n;
    logic [DOM_W-1:0]  d;
    logic              lo_per;
    logic              hi_per;
  } axis_cfg_t;

  // One axis of a classified particle. q is the padded cell coordinate (cell + 1).
  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic [Q_W-1:0]          q;
    logic                    plus_ok;
    logic                    minus_ok;
  } axis_ent_t;

  typedef struct packed {
    status_t              status;
    cls_t                 cls;
    axis_ent_t [2:0]      ax;
  } item_t;

  // Sides first, then edges, then corners.
  localparam dir_t GHOST_DIRS [NGHOST][3] = '{
    '{DIR_PLUS,  DIR_NONE,  DIR_NONE }, '{DIR_MINUS, DIR_NONE,  DIR_NONE },
    '{DIR_NONE,  DIR_PLUS,  DIR_NONE }, '{DIR_NONE,  DIR_MINUS, DIR_NONE },
    '{DIR_NONE,  DIR_NONE,  DIR_PLUS }, '{DIR_NONE,  DIR_NONE,  DIR_MINUS},
    '{DIR_PLUS,  DIR_PLUS,  DIR_NONE }, '{DIR_PLUS,  DIR_MINUS, DIR_NONE },
    '{DIR_MINUS, DIR_PLUS,  DIR_NONE }, '{DIR_MINUS, DIR_MINUS, DIR_NONE },
    '{DIR_PLUS,  DIR_NONE,  DIR_PLUS }, '{DIR_PLUS,  DIR_NONE,  DIR_MINUS},
    '{DIR_MINUS, DIR_NONE,  DIR_PLUS }, '{DIR_MINUS, DIR_NONE,  DIR_MINUS},
    '{DIR_NONE,  DIR_PLUS,  DIR_PLUS }, '{DIR_NONE,  DIR_PLUS,  DIR_MINUS},
    '{DIR_NONE,  DIR_MINUS, DIR_PLUS }, '{DIR_NONE,  DIR_MINUS, DIR_MINUS},
    '{DIR_PLUS,  DIR_PLUS,  DIR_PLUS }, '{DIR_PLUS,  DIR_PLUS,  DIR_MINUS},
    '{DIR_PLUS,  DIR_MINUS, DIR_PLUS }, '{DIR_PLUS,  DIR_MINUS, DIR_MINUS},
    '{DIR_MINUS, DIR_PLUS,  DIR_PLUS }, '{DIR_MINUS, DIR_PLUS,  DIR_MINUS},
    '{DIR_MINUS, DIR_MINUS, DIR_PLUS }, '{DIR_MINUS, DIR_MINUS, DIR_MINUS}
  };

endpackage

// ===== rtl/core/lcb_bin.sv =====
// One-axis binning pipeline: multiply by the cell count, then a bit-per-stage restoring divide.
module lcb_bin (
  input  logic                            clk,
  input  logic                            adv,
  input  logic signed [lcb_pkg::POS_W-1:0] pos_in,
  input  lcb_pkg::axis_cfg_t              cfg,
  output logic signed [lcb_pkg::POS_W-1:0] pos_o,
  output logic [lcb_pkg::Q_W-1:0]         q_o,
  output logic                            err_o
);
  import lcb_pkg::*;

  logic signed [POS_W-1:0] pos_r [BIN_STG];
  logic signed [NUM_W-1:0] num_r;
  logic [REM_W-1:0]        rem_r [1:BIN_STG-1];
  logic [Q_W-1:0]          q_r   [1:BIN_STG-1];
  logic                    err_r [1:BIN_STG-1];
  logic [REM_W-1:0]        rem_nxt [1:BIN_STG-2];
  logic                    bit_nxt [1:BIN_STG-2];

  logic signed [NUM_W-1:0] pos_ext, n_ext, num_nxt;
  logic signed [NUM_W:0]   rsum;
  logic [NUM_W-1:0]        lim;

  assign pos_ext = NUM_W'(pos_in);
  assign n_ext   = $signed(NUM_W'(cfg.n));
  assign num_nxt = pos_ext * n_ext;
  // Offset by one domain so the quotient is the padded coordinate and stays non-negative.
  assign rsum    = (NUM_W+1)'(num_r) + $signed((NUM_W+1)'(cfg.d));
  assign lim     = NUM_W'({cfg.d, {Q_W{1'b0}}});

  always_comb begin
    for (int i = 1; i <= BIN_STG-2; i++) begin
      logic [REM_W-1:0] dsh;
      dsh = REM_W'(cfg.d) << (BIN_STG-2-i);
      bit_nxt[i] = (rem_r[i] >= dsh);
      rem_nxt[i] = bit_nxt[i] ? (rem_r[i] - dsh) : rem_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_r[0] <= pos_in;
      num_r    <= num_nxt;
      pos_r[1] <= pos_r[0];
      rem_r[1] <= rsum[REM_W-1:0];
      q_r[1]   <= '0;
      err_r[1] <= rsum[NUM_W] || (rsum[NUM_W-1:0] >= lim);
      for (int i = 1; i <= BIN_STG-2; i++) begin
        pos_r[i+1] <= pos_r[i];
        rem_r[i+1] <= rem_nxt[i];
        q_r[i+1]   <= {q_r[i][Q_W-2:0], bit_nxt[i]};
        err_r[i+1] <= err_r[i];
      end
    end
  end

  assign pos_o = pos_r[BIN_STG-1];
  assign q_o   = q_r[BIN_STG-1];
  assign err_o = err_r[BIN_STG-1] || (q_r[BIN_STG-1] > (Q_W'(cfg.n) + Q_W'(1)));

endmodule

// ===== rtl/core/lcb_front.sv =====
// Front end: three axis binning pipelines, periodic wrap and classification of each word.
module lcb_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [lcb_pkg::POS_W-1:0] pos_in [3],
  input  lcb_pkg::axis_cfg_t [2:0]        cfg,
  input  logic                            q_full,
  output logic                            push,
  output lcb_pkg::item_t                  item
);
  import lcb_pkg::*;

  logic                    v_r [BIN_STG];
  logic                    adv;
  logic signed [POS_W-1:0] bpos [3];
  logic [Q_W-1:0]          bq   [3];
  logic                    berr [3];

  assign adv      = !v_r[BIN_STG-1] || !q_full;
  assign in_ready = adv;
  assign push     = v_r[BIN_STG-1] && !q_full;

  for (genvar a = 0; a < 3; a++) begin : g_ax
    lcb_bin u_bin (
      .clk    (clk),
      .adv    (adv),
      .pos_in (pos_in[a]),
      .cfg    (cfg[a]),
      .pos_o  (bpos[a]),
      .q_o    (bq[a]),
      .err_o  (berr[a])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < BIN_STG; s++) v_r[s] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
      for (int s = 1; s < BIN_STG; s++) v_r[s] <= v_r[s-1];
    end
  end

  always_comb begin
    logic err, halo, bnd;
    logic [Q_W-1:0] n1;
    err  = berr[0] || berr[1] || berr[2];
    halo = 1'b0;
    bnd  = 1'b0;
    item = '0;
    for (int a = 0; a < 3; a++) begin
      n1 = Q_W'(cfg[a].n) + Q_W'(1);
      item.ax[a].pos = bpos[a];
      item.ax[a].q   = bq[a];
      // A wrap moves exactly one domain, so the new coordinate is known without a second divide.
      if (bq[a] == '0 && cfg[a].lo_per) begin
        item.ax[a].pos = POS_W'(bpos[a] + $signed(POS_W'(cfg[a].d)));
        item.ax[a].q   = Q_W'(cfg[a].n);
      end else if (bq[a] == n1 && cfg[a].hi_per) begin
        item.ax[a].pos = POS_W'(bpos[a] - $signed(POS_W'(cfg[a].d)));
        item.ax[a].q   = Q_W'(1);
      end
      if (item.ax[a].q == '0 || item.ax[a].q == n1) halo = 1'b1;
      if (item.ax[a].q == Q_W'(1) || item.ax[a].q == Q_W'(cfg[a].n)) bnd = 1'b1;
      item.ax[a].plus_ok  = cfg[a].lo_per && item.ax[a].q == Q_W'(1);
      item.ax[a].minus_ok = cfg[a].hi_per && item.ax[a].q == Q_W'(cfg[a].n);
    end
    if (err) begin
      for (int a = 0; a < 3; a++) begin
        item.ax[a].pos      = bpos[a];
        item.ax[a].q        = '0;
        item.ax[a].plus_ok  = 1'b0;
        item.ax[a].minus_ok = 1'b0;
      end
      item.status = ST_ERROR;
      item.cls    = CLASS_INNER;
    end else if (halo) begin
      item.status = ST_DROP;
      item.cls    = CLASS_HALO;
    end else begin
      item.status = ST_HOME;
      item.cls    = bnd ? CLASS_BOUNDARY : CLASS_INNER;
    end
  end

endmodule

// ===== rtl/core/lcb_fifo.sv =====
// Small queue of classified words between the front and back ends.
module lcb_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lcb_pkg::item_t din,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output lcb_pkg::item_t dout
);
  import lcb_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t          mem_r [DEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + AW'(1);
      if (pop)  rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + AW'(1);
      if (push && !pop)      cnt_r <= cnt_r + (AW+1)'(1);
      else if (pop && !push) cnt_r <= cnt_r - (AW+1)'(1);
    end
  end

endmodule

// ===== rtl/core/lcb_back.sv =====
// Back end: puts each word in the output register, then a home word's periodic ghost images.
module lcb_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lcb_pkg::item_t                   head,
  input  logic                             head_valid,
  output logic                             pop,
  input  lcb_pkg::axis_cfg_t [2:0]         cfg,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [lcb_pkg::POS_W-1:0] out_x,
  output logic signed [lcb_pkg::POS_W-1:0] out_y,
  output logic signed [lcb_pkg::POS_W-1:0] out_z,
  output logic [lcb_pkg::IDX_W-1:0]        out_bin_index,
  output logic [1:0]                       out_cell_class,
  output logic [1:0]                       out_status,
  output logic                             out_last
);
  import lcb_pkg::*;

  localparam int SW = 2 * (CELL_W + 1);

  logic                    out_valid_r, last_r, busy_r;
  logic signed [POS_W-1:0] px_r, py_r, pz_r;
  logic [IDX_W-1:0]        idx_r;
  cls_t                    cls_r;
  status_t                 st_r;
  logic [NGHOST-1:0]       rem_r, mask, rem_nxt;
  logic [SW-1:0]           plane_r;
  logic [GSEL_W-1:0]       sel;
  logic                    load, fire, last_nxt;
  logic signed [POS_W-1:0] gpos [3];
  logic [Q_W-1:0]          gq   [3];
  cls_t                    cls_nxt;
  status_t                 st_nxt;
  logic [IDX_W-1:0]        idx_nxt;

  function automatic logic signed [POS_W-1:0] sat_shift(logic signed [POS_W-1:0] p,
                                                        logic [DOM_W-1:0] d, logic sub);
    logic signed [POS_W:0] s;
    s = sub ? ((POS_W+1)'(p) - $signed((POS_W+1)'(d)))
            : ((POS_W+1)'(p) + $signed((POS_W+1)'(d)));
    if (s[POS_W] != s[POS_W-1]) return s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}}
                                                : {1'b0, {(POS_W-1){1'b1}}};
    return s[POS_W-1:0];
  endfunction

  // Size of one x plane of the padded grid, kept in a register.
  always_ff @(posedge clk) begin
    plane_r <= SW'((CELL_W+1)'(cfg[1].n) + (CELL_W+1)'(2))
             * SW'((CELL_W+1)'(cfg[2].n) + (CELL_W+1)'(2));
  end

  always_comb begin
    for (int k = 0; k < NGHOST; k++) begin
      mask[k] = 1'b1;
      for (int a = 0; a < 3; a++) begin
        if (GHOST_DIRS[k][a] == DIR_PLUS  && !head.ax[a].plus_ok)  mask[k] = 1'b0;
        if (GHOST_DIRS[k][a] == DIR_MINUS && !head.ax[a].minus_ok) mask[k] = 1'b0;
      end
    end
    if (head.status != ST_HOME) mask = '0;
  end

  always_comb begin
    sel = '0;
    for (int k = NGHOST-1; k >= 0; k--) begin
      if (rem_r[k]) sel = GSEL_W'(k);
    end
    rem_nxt = rem_r & ~(NGHOST'(1) << sel);
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      gpos[a] = head.ax[a].pos;
      gq[a]   = head.ax[a].q;
      if (busy_r) begin
        unique case (GHOST_DIRS[sel][a])
          DIR_PLUS: begin
            gpos[a] = sat_shift(head.ax[a].pos, cfg[a].d, 1'b0);
            gq[a]   = Q_W'(cfg[a].n) + Q_W'(1);
          end
          DIR_MINUS: begin
            gpos[a] = sat_shift(head.ax[a].pos, cfg[a].d, 1'b1);
            gq[a]   = '0;
          end
          default: begin
            gpos[a] = head.ax[a].pos;
            gq[a]   = head.ax[a].q;
          end
        endcase
      end
    end
    // Products are formed at the full index width so the largest grid does not wrap.
    idx_nxt = IDX_W'(gq[0]) * IDX_W'(plane_r)
            + IDX_W'(gq[1]) * IDX_W'((CELL_W+1)'(cfg[2].n) + (CELL_W+1)'(2))
            + IDX_W'(gq[2]);
    if (busy_r) begin
      cls_nxt  = CLASS_HALO;
      st_nxt   = ST_GHOST;
      last_nxt = (rem_nxt == '0);
    end else begin
      cls_nxt  = head.cls;
      st_nxt   = head.status;
      last_nxt = (mask == '0);
    end
  end

  assign load = !out_valid_r || out_ready;
  assign fire = head_valid && load;
  assign pop  = fire && last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
      rem_r       <= '0;
    end else begin
      if (load) out_valid_r <= head_valid;
      if (fire) begin
        if (!busy_r) begin
          busy_r <= !last_nxt;
          rem_r  <= mask;
        end else begin
          busy_r <= !last_nxt;
          rem_r  <= rem_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      px_r   <= gpos[0];
      py_r   <= gpos[1];
      pz_r   <= gpos[2];
      idx_r  <= idx_nxt;
      cls_r  <= cls_nxt;
      st_r   <= st_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_x          = px_r;
  assign out_y          = py_r;
  assign out_z          = pz_r;
  assign out_bin_index  = idx_r;
  assign out_cell_class = cls_r;
  assign out_status     = st_r;
  assign out_last       = last_r;

endmodule

// ===== rtl/core/linked_cell_binning_periodic_images_unit.sv =====
// Top level of the linked-cell binning unit with periodic wrap and ghost images.
// An accepted word reaches the output register through the binning pipeline and the queue.
// Throughput: one word per cycle enters the binning pipeline unless the full queue stalls it;
// the back end sends one word per cycle under out_ready: a word and its ghosts, 27 at most.
// Reset: synchronous active-low rst_n clears the pipeline valids, queue and emitter state and
// loads the register defaults (domains 1.0, one cell per axis, all sides outflow).
module linked_cell_binning_periodic_images_unit #(
  parameter int QDEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [lcb_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [lcb_pkg::POS_W-1:0]  in_pos_y,
  input  logic signed [lcb_pkg::POS_W-1:0]  in_pos_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [lcb_pkg::POS_W-1:0]  out_x,
  output logic signed [lcb_pkg::POS_W-1:0]  out_y,
  output logic signed [lcb_pkg::POS_W-1:0]  out_z,
  output logic [lcb_pkg::IDX_W-1:0]         out_bin_index,
  output logic [1:0]                        out_cell_class,
  output logic [1:0]                        out_status,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lcb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lcb_pkg::CFG_DAT_W-1:0]     cfg_data
);
  import lcb_pkg::*;

  // Configuration registers, to be written by the user only while the block is idle; not checked.
  logic [DOM_W-1:0]   dom_r   [3];
  logic [CELL_W-1:0]  cells_r [3];
  logic [MODES_W-1:0] modes_r;

  axis_cfg_t [2:0]    acfg;
  logic signed [POS_W-1:0] pos_in [3];
  item_t              f_item, q_head;
  logic               f_push, q_full, q_empty, b_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        dom_r[a]   <= DOM_W'(65536);
        cells_r[a] <= CELL_W'(1);
      end
      modes_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DOMAIN_X: dom_r[0]   <= cfg_data[DOM_W-1:0];
        CFG_DOMAIN_Y: dom_r[1]   <= cfg_data[DOM_W-1:0];
        CFG_DOMAIN_Z: dom_r[2]   <= cfg_data[DOM_W-1:0];
        CFG_CELLS_X:  cells_r[0] <= cfg_data[CELL_W-1:0];
        CFG_CELLS_Y:  cells_r[1] <= cfg_data[CELL_W-1:0];
        CFG_CELLS_Z:  cells_r[2] <= cfg_data[CELL_W-1:0];
        CFG_MODES:    modes_r    <= cfg_data[MODES_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective setup: a zero cell count acts as one and counts above the grid limit are clamped;
  // a zero domain acts as the smallest step. Only mode 2 on a side makes it periodic.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      acfg[a].n = (cells_r[a] == '0) ? CELL_W'(1)
                : (cells_r[a] > CELL_W'(MAX_CELLS)) ? CELL_W'(MAX_CELLS) : cells_r[a];
      acfg[a].d      = (dom_r[a] == '0) ? DOM_W'(1) : dom_r[a];
      acfg[a].lo_per = (modes_r[4*a +: 2] == MODE_PERIODIC);
      acfg[a].hi_per = (modes_r[4*a+2 +: 2] == MODE_PERIODIC);
    end
  end

  assign pos_in[0] = in_pos_x;
  assign pos_in[1] = in_pos_y;
  assign pos_in[2] = in_pos_z;

  // The front end bins all three axes in a nine-stage pipeline and classifies each word as
  // kept, dropped or out of range; it only stalls when the queue is full.
  lcb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .pos_in   (pos_in),
    .cfg      (acfg),
    .q_full   (q_full),
    .push     (f_push),
    .item     (f_item)
  );

  // The queue absorbs bursts of ghost images so the front keeps taking words meanwhile.
  lcb_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   (f_item),
    .full  (q_full),
    .pop   (b_pop),
    .empty (q_empty),
    .dout  (q_head)
  );

  // The back end walks the home word and its ghost images, one word per cycle under out_ready.
  lcb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .head_valid     (!q_empty),
    .pop            (b_pop),
    .cfg            (acfg),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_z          (out_z),
    .out_bin_index  (out_bin_index),
    .out_cell_class (out_cell_class),
    .out_status     (out_status),
    .out_last       (out_last)
  );

endmodule

// ===== rtl/core/lcb_checker.sv =====
// Port-level checks for the linked-cell binning unit and their binding to the top level.
module lcb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [18:0] out_bin_index,
  input logic [1:0] out_cell_class,
  input logic [1:0] out_status,
  input logic       out_last
);
  import lcb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_ghost_halo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_GHOST |-> out_cell_class == CLASS_HALO)
    else $error("ghost image not in a halo cell");

  a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_ERROR |-> out_last && out_bin_index == '0)
    else $error("out of range word malformed");

  a_drop_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_DROP |-> out_last && out_cell_class == CLASS_HALO)
    else $error("dropped word malformed");

  a_ghost_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> !out_valid || out_status == ST_GHOST)
    else $error("ghost sequence broken");

endmodule

bind linked_cell_binning_periodic_images_unit lcb_checker u_lcb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_bin_index  (out_bin_index),
  .out_cell_class (out_cell_class),
  .out_status     (out_status),
  .out_last       (out_last)
);
